// ----- sv/tape_pulse_segment_encoder_macros.svh -----
// assertion macros for the tape pulse segment encoder
`ifndef TAPE_PULSE_SEGMENT_ENCODER_MACROS_SVH
`define TAPE_PULSE_SEGMENT_ENCODER_MACROS_SVH

// same-cycle implication, sampled on clock, off while rst is high
`define TPSE_ASSERT_NOW(label, rst, cond, prop) \
   label: assert property (@(posedge clock) disable iff (rst) (cond) |-> (prop)) \
      else $error("tpse assertion failed");

// next-cycle implication, sampled on clock, off while rst is high
`define TPSE_ASSERT_NEXT(label, rst, cond, prop) \
   label: assert property (@(posedge clock) disable iff (rst) (cond) |=> (prop)) \
      else $error("tpse assertion failed");

`endif

// ----- sv/tpse_pkg.sv -----
package tpse_pkg;

   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_CNT_W = 2;

   typedef enum logic [2:0] {
      REG_PILOT_HALF_LEN  = 3'd0,
      REG_PILOT_PAIRS     = 3'd1,
      REG_SYNC_FIRST_LEN  = 3'd2,
      REG_SYNC_SECOND_LEN = 3'd3,
      REG_ZERO_HALF_LEN   = 3'd4,
      REG_ONE_HALF_LEN    = 3'd5,
      REG_SILENCE_LEN     = 3'd6,
      REG_AMPLITUDE       = 3'd7
   } reg_index_type;

   typedef enum logic [2:0] {
      KIND_PILOT   = 3'd0,
      KIND_SYNC1   = 3'd1,
      KIND_SYNC2   = 3'd2,
      KIND_ZERO    = 3'd3,
      KIND_ONE     = 3'd4,
      KIND_SILENCE = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      STEP_PILOT,
      STEP_SYNC1,
      STEP_SYNC2,
      STEP_BIT,
      STEP_SILENCE
   } step_type;

   localparam logic [15:0] RESET_PILOT_HALF_LEN  = 16'd27;
   localparam logic [15:0] RESET_PILOT_PAIRS     = 16'd2450;
   localparam logic [15:0] RESET_SYNC_FIRST_LEN  = 16'd8;
   localparam logic [15:0] RESET_SYNC_SECOND_LEN = 16'd9;
   localparam logic [15:0] RESET_ZERO_HALF_LEN   = 16'd11;
   localparam logic [15:0] RESET_ONE_HALF_LEN    = 16'd22;
   localparam logic [15:0] RESET_SILENCE_LEN     = 16'd44;
   localparam logic [14:0] RESET_AMPLITUDE       = 15'd32760;

   typedef struct packed {
      logic [15:0] pilot_half_len;
      logic [15:0] pilot_pairs;
      logic [15:0] sync_first_len;
      logic [15:0] sync_second_len;
      logic [15:0] zero_half_len;
      logic [15:0] one_half_len;
      logic [15:0] silence_len;
      logic [14:0] amplitude;
   } cfg_type;

   // one queued word, already classified by the front
   typedef struct packed {
      logic [7:0] data_byte;
      logic       do_pilot;
      logic       do_sync;
      logic       do_silence;
   } cmd_type;

   // handshake between queue and sequencer
   typedef struct packed {
      logic valid;
      logic pop;
   } cmd_ctrl_type;

endpackage

// ----- sv/tpse_if.sv -----
interface tpse_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       first_of_block;
   logic       last_of_block;

   modport source (output valid, data_byte, first_of_block, last_of_block, input ready);
   modport sink (input valid, data_byte, first_of_block, last_of_block, output ready);
endinterface

interface tpse_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] start_level;
   logic [15:0]        half_len;
   logic [16:0]        half_count;
   logic [2:0]         segment_kind;
   logic               last;

   modport source (output valid, start_level, half_len, half_count, segment_kind, last,
                   input ready);
   modport sink (input valid, start_level, half_len, half_count, segment_kind, last,
                 output ready);
endinterface

// ----- sv/tpse_csr.sv -----
module tpse_csr import tpse_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          write_en;

   assign pready   = 1'b1;
   assign index    = reg_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign write_en = psel && penable && pwrite && pready;
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            REG_PILOT_HALF_LEN:  cfg_in.pilot_half_len  = pwdata[15:0];
            REG_PILOT_PAIRS:     cfg_in.pilot_pairs     = pwdata[15:0];
            REG_SYNC_FIRST_LEN:  cfg_in.sync_first_len  = pwdata[15:0];
            REG_SYNC_SECOND_LEN: cfg_in.sync_second_len = pwdata[15:0];
            REG_ZERO_HALF_LEN:   cfg_in.zero_half_len   = pwdata[15:0];
            REG_ONE_HALF_LEN:    cfg_in.one_half_len    = pwdata[15:0];
            REG_SILENCE_LEN:     cfg_in.silence_len     = pwdata[15:0];
            REG_AMPLITUDE:       cfg_in.amplitude       = pwdata[14:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_PILOT_HALF_LEN:  prdata = {16'd0, cfg_ff.pilot_half_len};
         REG_PILOT_PAIRS:     prdata = {16'd0, cfg_ff.pilot_pairs};
         REG_SYNC_FIRST_LEN:  prdata = {16'd0, cfg_ff.sync_first_len};
         REG_SYNC_SECOND_LEN: prdata = {16'd0, cfg_ff.sync_second_len};
         REG_ZERO_HALF_LEN:   prdata = {16'd0, cfg_ff.zero_half_len};
         REG_ONE_HALF_LEN:    prdata = {16'd0, cfg_ff.one_half_len};
         REG_SILENCE_LEN:     prdata = {16'd0, cfg_ff.silence_len};
         REG_AMPLITUDE:       prdata = {17'd0, cfg_ff.amplitude};
         default:             prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pilot_half_len  <= RESET_PILOT_HALF_LEN;
         cfg_ff.pilot_pairs     <= RESET_PILOT_PAIRS;
         cfg_ff.sync_first_len  <= RESET_SYNC_FIRST_LEN;
         cfg_ff.sync_second_len <= RESET_SYNC_SECOND_LEN;
         cfg_ff.zero_half_len   <= RESET_ZERO_HALF_LEN;
         cfg_ff.one_half_len    <= RESET_ONE_HALF_LEN;
         cfg_ff.silence_len     <= RESET_SILENCE_LEN;
         cfg_ff.amplitude       <= RESET_AMPLITUDE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- sv/tpse_front.sv -----
module tpse_front import tpse_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   tpse_req_if.sink     req,
   input  cfg_type      cfg,
   output cmd_type      cmd,
   output cmd_ctrl_type cmd_ctrl_out,
   input  logic         cmd_pop
);

   cmd_type                queue_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0] count_ff;
   logic [QUEUE_CNT_W-1:0] count_in;
   logic                   push;
   cmd_type                classified;

   assign req.ready = count_ff != QUEUE_CNT_W'(QUEUE_DEPTH);
   assign push      = req.valid && req.ready;

   // pilot is dropped when no pilot pairs are asked for
   assign classified.data_byte  = req.data_byte;
   assign classified.do_pilot   = req.first_of_block && (cfg.pilot_pairs != 16'd0);
   assign classified.do_sync    = req.first_of_block;
   assign classified.do_silence = req.last_of_block;

   assign cmd                = queue_ff[rd_ptr_ff];
   assign cmd_ctrl_out.valid = count_ff != '0;
   assign cmd_ctrl_out.pop   = cmd_pop;

   always_comb begin
      count_in = count_ff;
      if (push && !cmd_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && cmd_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= classified;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (cmd_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

endmodule

// ----- sv/tpse_back.sv -----
module tpse_back import tpse_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  cmd_type      cmd,
   input  cmd_ctrl_type cmd_ctrl,
   output logic         cmd_pop,
   tpse_rsp_if.source   rsp
);

   logic               busy_ff;
   logic               busy_in;
   step_type           step_ff;
   step_type           step_in;
   logic [2:0]         bit_ff;
   logic [2:0]         bit_in;
   cmd_type            work_ff;

   cmd_type            work;
   step_type           step;
   logic [2:0]         bit_idx;
   logic               emit;
   logic               advance;
   logic               seg_last;
   step_type           next_step;

   logic               out_valid_ff;
   logic signed [15:0] level_ff;
   logic [15:0]        len_ff;
   logic [16:0]        count_ff;
   kind_type           kind_ff;
   logic               last_ff;

   logic signed [15:0] level_in;
   logic [15:0]        len_in;
   logic [16:0]        count_in;
   kind_type           kind_in;
   logic signed [15:0] level_high;
   logic signed [15:0] level_low;

   assign level_high = signed'({1'b0, cfg.amplitude});
   assign level_low  = -level_high;

   // a fresh command starts straight from the queue head
   always_comb begin
      work    = busy_ff ? work_ff : cmd;
      bit_idx = busy_ff ? bit_ff : 3'd7;
      if (busy_ff) begin
         step = step_ff;
      end else if (cmd.do_pilot) begin
         step = STEP_PILOT;
      end else if (cmd.do_sync) begin
         step = STEP_SYNC1;
      end else begin
         step = STEP_BIT;
      end
   end

   assign emit    = busy_ff || cmd_ctrl.valid;
   assign advance = emit && (!out_valid_ff || rsp.ready);
   assign cmd_pop = advance && !busy_ff;

   always_comb begin
      seg_last  = 1'b0;
      next_step = step;
      level_in  = level_low;
      len_in    = cfg.pilot_half_len;
      count_in  = {cfg.pilot_pairs, 1'b0};
      kind_in   = KIND_PILOT;
      unique case (step)
         STEP_PILOT: begin
            next_step = STEP_SYNC1;
         end
         STEP_SYNC1: begin
            next_step = STEP_SYNC2;
            len_in    = cfg.sync_first_len;
            count_in  = 17'd1;
            kind_in   = KIND_SYNC1;
         end
         STEP_SYNC2: begin
            next_step = STEP_BIT;
            level_in  = level_high;
            len_in    = cfg.sync_second_len;
            count_in  = 17'd1;
            kind_in   = KIND_SYNC2;
         end
         STEP_BIT: begin
            count_in = 17'd2;
            if (work.data_byte[bit_idx]) begin
               len_in  = cfg.one_half_len;
               kind_in = KIND_ONE;
            end else begin
               len_in  = cfg.zero_half_len;
               kind_in = KIND_ZERO;
            end
            if (bit_idx == 3'd0) begin
               next_step = STEP_SILENCE;
               seg_last  = !work.do_silence;
            end
         end
         STEP_SILENCE: begin
            seg_last = 1'b1;
            level_in = '0;
            len_in   = cfg.silence_len;
            count_in = 17'd1;
            kind_in  = KIND_SILENCE;
         end
         default: begin
            seg_last = 1'b1;
         end
      endcase
   end

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      bit_in  = bit_ff;
      if (advance) begin
         busy_in = !seg_last;
         step_in = next_step;
         if (step == STEP_BIT) begin
            bit_in = bit_idx - 3'd1;
         end else begin
            bit_in = 3'd7;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         work_ff <= cmd;
      end
      if (advance) begin
         level_ff <= level_in;
         len_ff   <= len_in;
         count_ff <= count_in;
         kind_ff  <= kind_in;
         last_ff  <= seg_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= STEP_PILOT;
         bit_ff       <= 3'd7;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
         bit_ff  <= bit_in;
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.start_level  = level_ff;
   assign rsp.half_len     = len_ff;
   assign rsp.half_count   = count_ff;
   assign rsp.segment_kind = kind_ff;
   assign rsp.last         = last_ff;

endmodule

// ----- sv/tape_pulse_segment_encoder.sv -----
// tape pulse segment encoder
// req_chan takes one tape byte per word with first and last block flags.
// rsp_chan gives square-wave segments: start level, half length, half count,
// kind and a last flag on the final segment of each byte.
// a byte gives 8 segments, plus pilot (unless zero pilot pairs) and two sync
// halves at the start of a block, plus silence at its end: 8 to 12 in all.
// the first segment reaches rsp_chan via the queue and the output register,
// then one per cycle while rsp_chan.ready is high; the segment sequencer sets
// that rate, and bytes follow without gaps while the queue holds the next.
// a two-word queue sits between the input stage and the sequencer, so input
// words are taken while the sequencer is busy or the output is stalled.
// when rsp_chan.ready is low the output register holds its word and the
// sequencer waits; the queue then fills and req_chan.ready falls.
// csr_* is an apb-style port; registers sit at byte address 4*index and
// should only be written while the block is idle.
// reset (synchronous) empties the queue and output and restores register
// defaults.
`include "tape_pulse_segment_encoder_macros.svh"

module tape_pulse_segment_encoder import tpse_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   tpse_req_if.sink              req_chan,
   tpse_rsp_if.source            rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type      cfg;
   cmd_type      cmd;
   cmd_ctrl_type cmd_ctrl;
   logic         cmd_pop;
   logic         rsp_silence;

   tpse_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   tpse_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req          (req_chan),
      .cfg          (cfg),
      .cmd          (cmd),
      .cmd_ctrl_out (cmd_ctrl),
      .cmd_pop      (cmd_pop)
   );

   tpse_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .cmd      (cmd),
      .cmd_ctrl (cmd_ctrl),
      .cmd_pop  (cmd_pop),
      .rsp      (rsp_chan)
   );

   assign rsp_silence = rsp_chan.valid && (rsp_chan.segment_kind == KIND_SILENCE);

   `TPSE_ASSERT_NOW(a_pop_needs_word, reset, cmd_ctrl.pop, cmd_ctrl.valid)
   `TPSE_ASSERT_NOW(a_silence_is_last, reset, rsp_silence, rsp_chan.last)
   `TPSE_ASSERT_NEXT(a_reset_empty, 1'b0, reset, !rsp_chan.valid && !cmd_ctrl.valid)

endmodule

// ----- dv/tb_tape_pulse_segment_encoder.sv -----
module tb_tape_pulse_segment_encoder;
   import tpse_pkg::*;

   localparam int QUIET_LIMIT = 2000;

   typedef struct {
      logic [7:0] data;
      logic       first;
      logic       last;
   } tape_word_type;

   typedef struct {
      logic signed [15:0] level;
      logic [15:0]        len;
      logic [16:0]        count;
      logic [2:0]         kind;
      logic               last;
   } segment_type;

   logic clock = 1'b0;
   logic reset;

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   tpse_req_if req_chan ();
   tpse_rsp_if rsp_chan ();

   tape_pulse_segment_encoder dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   cfg_type       tape_cfg;
   tape_word_type pending_words[$];
   tape_word_type word_out;
   segment_type   segments_due[$];
   int unsigned   send_idle_pct;
   int unsigned   take_idle_pct;
   int unsigned   send_hold;
   int unsigned   take_hold;
   int unsigned   quiet_cycles;
   int unsigned   fault_count;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic segment_type shape(logic signed [15:0] level, logic [15:0] len,
                                         logic [16:0] count, kind_type kind);
      segment_type s;
      s.level = level;
      s.len   = len;
      s.count = count;
      s.kind  = kind;
      s.last  = 1'b0;
      return s;
   endfunction

   function automatic void predict_segments(logic [7:0] data, logic first, logic last);
      segment_type        seg[$];
      logic signed [15:0] high_level;
      logic signed [15:0] low_level;
      high_level = {1'b0, tape_cfg.amplitude};
      low_level  = -high_level;
      if (first) begin
         if (tape_cfg.pilot_pairs != 16'd0)
            seg.push_back(shape(low_level, tape_cfg.pilot_half_len,
                                {tape_cfg.pilot_pairs, 1'b0}, KIND_PILOT));
         seg.push_back(shape(low_level, tape_cfg.sync_first_len, 17'd1, KIND_SYNC1));
         seg.push_back(shape(high_level, tape_cfg.sync_second_len, 17'd1, KIND_SYNC2));
      end
      for (int b = 7; b >= 0; b--) begin
         if (data[b])
            seg.push_back(shape(low_level, tape_cfg.one_half_len, 17'd2, KIND_ONE));
         else
            seg.push_back(shape(low_level, tape_cfg.zero_half_len, 17'd2, KIND_ZERO));
      end
      if (last)
         seg.push_back(shape(16'sd0, tape_cfg.silence_len, 17'd1, KIND_SILENCE));
      foreach (seg[i]) begin
         seg[i].last = (i == seg.size() - 1);
         segments_due.push_back(seg[i]);
      end
   endfunction

   function automatic void compare_field(string name, logic signed [17:0] want,
                                         logic signed [17:0] got);
      if (got !== want) begin
         fault_count++;
         $error("%s: expected %0d, got %0d", name, want, got);
      end
   endfunction

   function automatic void check_segment();
      segment_type want;
      if (segments_due.size() == 0) begin
         fault_count++;
         $error("segment of kind %0d with no byte behind it", rsp_chan.segment_kind);
      end else begin
         want = segments_due.pop_front();
         compare_field("start_level", want.level, rsp_chan.start_level);
         compare_field("half_len", {2'b00, want.len}, {2'b00, rsp_chan.half_len});
         compare_field("half_count", {1'b0, want.count}, {1'b0, rsp_chan.half_count});
         compare_field("segment_kind", {15'd0, want.kind}, {15'd0, rsp_chan.segment_kind});
         compare_field("last", {17'd0, want.last}, {17'd0, rsp_chan.last});
      end
   endfunction

   // sender: words leave the pending queue, prediction happens on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         send_hold <= 0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            predict_segments(req_chan.data_byte, req_chan.first_of_block,
                             req_chan.last_of_block);
         if (!req_chan.valid || req_chan.ready) begin
            if (send_hold != 0) begin
               send_hold <= send_hold - 1;
               req_chan.valid <= 1'b0;
            end else if (pending_words.size() != 0 && $urandom_range(99) < send_idle_pct) begin
               send_hold <= $urandom_range(11);
               req_chan.valid <= 1'b0;
            end else if (pending_words.size() != 0) begin
               word_out = pending_words.pop_front();
               req_chan.valid <= 1'b1;
               req_chan.data_byte <= word_out.data;
               req_chan.first_of_block <= word_out.first;
               req_chan.last_of_block <= word_out.last;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         take_hold <= 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready)
            check_segment();
         if (take_hold != 0) begin
            take_hold <= take_hold - 1;
            rsp_chan.ready <= 1'b0;
         end else if ($urandom_range(99) < take_idle_pct) begin
            take_hold <= $urandom_range(11);
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || csr_psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_register(reg_index_type idx, logic [15:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= {16'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_PILOT_HALF_LEN:  tape_cfg.pilot_half_len = value;
         REG_PILOT_PAIRS:     tape_cfg.pilot_pairs = value;
         REG_SYNC_FIRST_LEN:  tape_cfg.sync_first_len = value;
         REG_SYNC_SECOND_LEN: tape_cfg.sync_second_len = value;
         REG_ZERO_HALF_LEN:   tape_cfg.zero_half_len = value;
         REG_ONE_HALF_LEN:    tape_cfg.one_half_len = value;
         REG_SILENCE_LEN:     tape_cfg.silence_len = value;
         REG_AMPLITUDE:       tape_cfg.amplitude = value[14:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(cfg_type c);
      write_register(REG_PILOT_HALF_LEN, c.pilot_half_len);
      write_register(REG_PILOT_PAIRS, c.pilot_pairs);
      write_register(REG_SYNC_FIRST_LEN, c.sync_first_len);
      write_register(REG_SYNC_SECOND_LEN, c.sync_second_len);
      write_register(REG_ZERO_HALF_LEN, c.zero_half_len);
      write_register(REG_ONE_HALF_LEN, c.one_half_len);
      write_register(REG_SILENCE_LEN, c.silence_len);
      write_register(REG_AMPLITUDE, {1'b0, c.amplitude});
      @(negedge clock);
   endtask

   function automatic logic [15:0] pick_length();
      case ($urandom_range(9))
         0: return 16'd0;
         1: return 16'hFFFF;
         2: return 16'($urandom);
         default: return 16'($urandom_range(1, 400));
      endcase
   endfunction

   function automatic cfg_type random_settings();
      cfg_type     c;
      logic [15:0] amp;
      c.pilot_half_len  = pick_length();
      c.pilot_pairs     = pick_length();
      c.sync_first_len  = pick_length();
      c.sync_second_len = pick_length();
      c.zero_half_len   = pick_length();
      c.one_half_len    = pick_length();
      c.silence_len     = pick_length();
      amp = 16'($urandom);
      c.amplitude = amp[14:0];
      return c;
   endfunction

   task automatic queue_word(logic [7:0] data, logic first, logic last);
      tape_word_type w;
      w.data  = data;
      w.first = first;
      w.last  = last;
      pending_words.push_back(w);
   endtask

   // mostly whole blocks with random bytes, some stray words with random flags
   task automatic queue_blocks(int unsigned n_words);
      int unsigned left;
      int unsigned span;
      left = n_words;
      while (left != 0) begin
         if ($urandom_range(9) == 0) begin
            queue_word(8'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)));
            left--;
         end else begin
            span = $urandom_range(1, 8);
            if (span > left)
               span = left;
            for (int i = 0; i < span; i++)
               queue_word(8'($urandom), i == 0, i == span - 1);
            left -= span;
         end
      end
   endtask

   task automatic settle();
      do @(negedge clock);
      while (pending_words.size() != 0 || req_chan.valid || segments_due.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   initial begin
      cfg_type c;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.data_byte = 8'd0;
      req_chan.first_of_block = 1'b0;
      req_chan.last_of_block = 1'b0;
      rsp_chan.ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      send_idle_pct = 0;
      take_idle_pct = 0;
      fault_count = 0;
      tape_cfg.pilot_half_len  = RESET_PILOT_HALF_LEN;
      tape_cfg.pilot_pairs     = RESET_PILOT_PAIRS;
      tape_cfg.sync_first_len  = RESET_SYNC_FIRST_LEN;
      tape_cfg.sync_second_len = RESET_SYNC_SECOND_LEN;
      tape_cfg.zero_half_len   = RESET_ZERO_HALF_LEN;
      tape_cfg.one_half_len    = RESET_ONE_HALF_LEN;
      tape_cfg.silence_len     = RESET_SILENCE_LEN;
      tape_cfg.amplitude       = RESET_AMPLITUDE;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // defaults after reset
      queue_word(8'h00, 1'b1, 1'b0);
      queue_word(8'hFF, 1'b0, 1'b0);
      queue_word(8'h80, 1'b0, 1'b0);
      queue_word(8'h01, 1'b0, 1'b1);
      queue_word(8'hA5, 1'b1, 1'b1);
      queue_word(8'h5A, 1'b0, 1'b0);
      settle();

      // everything at its top value
      c = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 15'h7FFF};
      apply_settings(c);
      queue_word(8'hAA, 1'b1, 1'b0);
      queue_word(8'h55, 1'b0, 1'b1);
      queue_word(8'hFF, 1'b1, 1'b1);
      settle();

      // zero lengths, no pilot, zero amplitude
      c = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 15'd0};
      apply_settings(c);
      queue_word(8'h3C, 1'b1, 1'b1);
      queue_word(8'hC3, 1'b1, 1'b0);
      queue_word(8'h00, 1'b0, 1'b1);
      settle();

      // single pilot pair, shortest non-zero lengths
      c = '{16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 15'd1};
      apply_settings(c);
      queue_word(8'h81, 1'b1, 1'b1);
      queue_word(8'h7E, 1'b1, 1'b0);
      settle();

      for (int p = 0; p < 6; p++) begin
         apply_settings(random_settings());
         if (p == 5) begin
            send_idle_pct = 0;
            take_idle_pct = 0;
         end else begin
            send_idle_pct = $urandom_range(2) * 15;
            take_idle_pct = $urandom_range(2) * 10;
         end
         queue_blocks(55);
         settle();
      end

      repeat (20) @(posedge clock);
      if (fault_count == 0 && segments_due.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
